[hw/rtl/scalc_pkg.sv]
package scalc_pkg;

   typedef enum logic [2:0] {
      OP_PUSH = 3'd0,
      OP_POP  = 3'd1,
      OP_ADD  = 3'd2,
      OP_SUB  = 3'd3,
      OP_MUL  = 3'd4,
      OP_DIV  = 3'd5,
      OP_DUP  = 3'd6,
      OP_SQRT = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_UNDER   = 3'd1,
      ST_OVER    = 3'd2,
      ST_DIVZERO = 3'd3,
      ST_NEGROOT = 3'd4,
      ST_SAT     = 3'd5
   } status_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] top_value;
      logic [4:0]         stack_depth;
      logic [2:0]         status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD1,
      S_RD2,
      S_EXEC,
      S_ITER,
      S_WRITE,
      S_RDTOP,
      S_TOPWAIT,
      S_RESP
   } state_type;

   // Controller to datapath. The memory reads entry sp-1 unless rd_next is set.
   typedef struct packed {
      logic capture;   // latch the request
      logic rd_next;   // read entry sp-2
      logic grab_r;    // latch read data as right operand
      logic exec;      // evaluate checks and start the iterative unit
      logic iter;      // one iteration step
      logic commit;    // write result and update the pointer
      logic grab_top;  // latch read data as the reported top
      logic load_rsp;  // load the output register
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic need_iter; // the operation runs on the iterative unit
      logic iter_done;
      logic rsp_busy;  // output register holds an untaken result
   } sts_type;

   localparam int unsigned DivSteps  = 48;
   localparam int unsigned SqrtSteps = 24;

endpackage

[hw/rtl/stack_calculator_core.sv]
// Stack calculator core: an RPN calculator on a bounded stack of Q16.16 words.
// Each request transaction carries an operation (push, pop, add, sub, mul,
// div, dup, sqrt) and a push value; every request yields exactly one response
// transaction with the new top, the depth and a status code.
// For sub and div the entry below the top is the left operand. Underflow,
// overflow, divide by zero and a negative root leave the stack unchanged;
// results that leave the 32-bit range saturate and report status saturated.
// Channels use valid/stall; a transaction moves when valid is high and stall
// low. The core handles one request at a time. Sqrt and div run on the
// shared iterative divide / square-root unit, which resolves one result bit
// per cycle; push, pop, dup, add, sub and mul do not use it. req_stall is
// low only while the core waits for a request. The response sits in an
// output register; if the receiver stalls, it holds there and the core
// waits before loading the next one.
// Reset is synchronous and active high; it empties the stack and drops any
// pending response. Stack entries need no clearing, since only entries below
// the pointer are ever used.
module stack_calculator_core
   import scalc_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   scalc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   scalc_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[hw/rtl/scalc_ctrl.sv]
module scalc_ctrl
   import scalc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_RD1;
            end
         end
         S_RD1: begin
            state_in   = S_RD2;
         end
         S_RD2: begin
            cmd.grab_r  = 1'b1;
            cmd.rd_next = 1'b1;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec   = 1'b1;
            state_in   = S_ITER;
         end
         S_ITER: begin
            if (sts.need_iter && !sts.iter_done) begin
               cmd.iter = 1'b1;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.commit = 1'b1;
            state_in   = S_RDTOP;
         end
         S_RDTOP: begin
            state_in   = S_TOPWAIT;
         end
         S_TOPWAIT: begin
            cmd.grab_top = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

[hw/rtl/scalc_datapath.sv]
module scalc_datapath
   import scalc_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned PW = $clog2(STACK_DEPTH + 1);

   logic [31:0] mem [STACK_DEPTH];
   logic [31:0] rd_data_ff;
   logic        wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0] wr_data;

   logic [PW-1:0] sp_ff, sp_in;
   op_type        op_ff;
   logic [31:0]   pv_ff;
   logic [31:0]   r_ff, top_ff;
   logic [2:0]    status_ff, status_in;
   logic [31:0]   res_ff, res_in;
   logic          iter_ff, iter_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   // Divider / square-root shared registers.
   logic [47:0]   quo_ff, quo_in;   // dividend shifted out / root result
   logic [48:0]   rem_ff, rem_in;
   logic [31:0]   dvs_ff, dvs_in;
   logic [47:0]   rad_ff, rad_in;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic [PW-1:0] sp_m1, sp_m2;
   assign sp_m1 = sp_ff - PW'(1);
   assign sp_m2 = sp_ff - PW'(2);

   always_comb begin
      rd_addr = AW'(sp_m1);
      if (cmd.rd_next) rd_addr = AW'(sp_m2);
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // Combinational evaluation at exec: checks, add/sub, mul.
   logic signed [32:0] sum, dif;
   logic [31:0] ml, mr;
   logic [63:0] prod;
   logic        opneg;
   logic [31:0] l_now;
   assign l_now = rd_data_ff;
   assign sum   = $signed({l_now[31], l_now}) + $signed({r_ff[31], r_ff});
   assign dif   = $signed({l_now[31], l_now}) - $signed({r_ff[31], r_ff});
   assign ml    = l_now[31] ? (32'd0 - l_now) : l_now;
   assign mr    = r_ff[31] ? (32'd0 - r_ff) : r_ff;
   assign opneg = l_now[31] ^ r_ff[31];
   assign prod  = ml * mr;

   function automatic logic [32:0] sat_sign(input logic neg, input logic [47:0] mag);
      logic [32:0] o;
      if (neg) begin
         if (mag > 48'h80000000) o = {1'b1, 32'h80000000};
         else o = {1'b0, 32'd0 - mag[31:0]};
      end else begin
         if (mag > 48'h7FFFFFFF) o = {1'b1, 32'h7FFFFFFF};
         else o = {1'b0, mag[31:0]};
      end
      return o;
   endfunction

   logic [32:0] satv;
   logic [48:0] trial;
   logic [49:0] strial;
   logic [49:0] sq_rem_sh;

   always_comb begin
      sp_in     = sp_ff;
      status_in = status_ff;
      res_in    = res_ff;
      iter_in   = iter_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      rad_in    = rad_ff;
      wr_en     = 1'b0;
      wr_addr   = AW'(sp_m1);
      wr_data   = res_ff;
      satv      = '0;
      trial     = '0;
      strial    = '0;
      sq_rem_sh = '0;
      if (cmd.exec) begin
         status_in = ST_OK;
         iter_in   = 1'b0;
         cnt_in    = '0;
         neg_in    = opneg;
         case (op_ff)
            OP_PUSH: begin
               if (sp_ff >= PW'(STACK_DEPTH)) status_in = ST_OVER;
               else begin
                  res_in   = pv_ff;
               end
            end
            OP_POP: begin
               if (sp_ff == '0) status_in = ST_UNDER;
            end
            OP_DUP: begin
               if (sp_ff == '0) status_in = ST_UNDER;
               else if (sp_ff >= PW'(STACK_DEPTH)) status_in = ST_OVER;
               else begin
                  res_in   = r_ff;
               end
            end
            OP_SQRT: begin
               if (sp_ff == '0) status_in = ST_UNDER;
               else if (r_ff[31]) status_in = ST_NEGROOT;
               else begin
                  iter_in = 1'b1;
                  rad_in  = {r_ff, 16'd0};
                  rem_in  = '0;
                  quo_in  = '0;
               end
            end
            default: begin
               if (sp_ff < PW'(2)) status_in = ST_UNDER;
               else if (op_ff == OP_ADD || op_ff == OP_SUB) begin
                  satv = (op_ff == OP_ADD) ?
                     ((sum[32] != sum[31]) ? {1'b1, sum[32] ? 32'h80000000 : 32'h7FFFFFFF}
                                           : {1'b0, sum[31:0]}) :
                     ((dif[32] != dif[31]) ? {1'b1, dif[32] ? 32'h80000000 : 32'h7FFFFFFF}
                                           : {1'b0, dif[31:0]});
                  res_in = satv[31:0];
                  if (satv[32]) status_in = ST_SAT;
               end else if (op_ff == OP_MUL) begin
                  satv   = sat_sign(opneg, prod[63:16]);
                  res_in = satv[31:0];
                  if (satv[32]) status_in = ST_SAT;
               end else if (mr == '0) begin
                  status_in = ST_DIVZERO;
               end else begin
                  iter_in = 1'b1;
                  quo_in  = {ml, 16'd0};
                  rem_in  = '0;
                  dvs_in  = mr;
               end
            end
         endcase
      end
      if (cmd.iter) begin
         cnt_in = cnt_ff + 6'd1;
         if (op_ff == OP_DIV) begin
            // Restoring division, one quotient bit per cycle.
            trial = {rem_ff[47:0], quo_ff[47]};
            if (trial >= {17'd0, dvs_ff}) begin
               rem_in = trial - {17'd0, dvs_ff};
               quo_in = {quo_ff[46:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[46:0], 1'b0};
            end
         end else begin
            // Digit-by-digit square root, one result bit per cycle.
            sq_rem_sh = {rem_ff[47:0], rad_ff[47:46]};
            strial    = {quo_ff, 2'b01};
            if (sq_rem_sh >= strial) begin
               rem_in = 49'(sq_rem_sh - strial);
               quo_in = {quo_ff[46:0], 1'b1};
            end else begin
               rem_in = sq_rem_sh[48:0];
               quo_in = {quo_ff[46:0], 1'b0};
            end
            rad_in = {rad_ff[45:0], 2'b00};
         end
      end
      if (cmd.commit) begin
         if (status_ff == ST_OK || status_ff == ST_SAT) begin
            case (op_ff)
               OP_PUSH, OP_DUP: begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(sp_ff);
                  wr_data = res_ff;
                  sp_in   = sp_ff + PW'(1);
               end
               OP_POP: sp_in = sp_m1;
               OP_SQRT: begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(sp_m1);
                  wr_data = quo_ff[31:0];
               end
               OP_DIV: begin
                  satv    = sat_sign(neg_ff, quo_ff);
                  wr_en   = 1'b1;
                  wr_addr = AW'(sp_m2);
                  wr_data = satv[31:0];
                  sp_in   = sp_m1;
                  if (satv[32]) status_in = ST_SAT;
               end
               default: begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(sp_m2);
                  wr_data = res_ff;
                  sp_in   = sp_m1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         iter_ff      <= 1'b0;
         cnt_ff       <= '0;
         status_ff    <= ST_OK;
      end else begin
         sp_ff     <= sp_in;
         iter_ff   <= iter_in;
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
         if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      res_ff   <= res_in;
      neg_ff   <= neg_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      rad_ff   <= rad_in;
      if (cmd.capture) begin
         op_ff <= op_type'(req_data.operation);
         pv_ff <= req_data.push_value;
      end
      if (cmd.grab_r) r_ff <= rd_data_ff;
      if (cmd.grab_top) top_ff <= (sp_ff == '0) ? 32'd0 : rd_data_ff;
      if (cmd.load_rsp) begin
         rsp_ff.top_value   <= top_ff;
         rsp_ff.stack_depth <= 5'(sp_ff);
         rsp_ff.status      <= status_ff;
      end
   end

   assign sts.need_iter = iter_ff;
   assign sts.iter_done = (op_ff == OP_DIV) ? (cnt_ff == 6'(DivSteps))
                                            : (cnt_ff == 6'(SqrtSteps));
   assign sts.rsp_busy  = rsp_valid_ff && rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;

   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= PW'(STACK_DEPTH)) else $error("stack pointer past depth");
   a_sp_only_commit: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.commit) |-> $stable(sp_ff)) else $error("pointer moved off commit");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff) else $error("result dropped");

endmodule
